FILE: rtl/core/jcc_pkg.sv
`default_nettype none
package jcc_pkg;

  localparam int TIMER_BITS_DEF = 16;
  localparam int YEAR_BITS_DEF  = 16;

  localparam logic [15:0] TPS_RESET    = 16'd60;
  localparam logic [5:0]  SEC_LIMIT    = 6'd60;
  localparam logic [5:0]  MIN_LIMIT    = 6'd60;
  localparam logic [4:0]  HOUR_LIMIT   = 5'd24;
  localparam logic [4:0]  LAST_MONTH   = 5'd11;
  localparam logic [3:0]  MONTH_FEB    = 4'd1;
  localparam logic [4:0]  LONG_MONTH   = 5'd31;

  localparam logic [5:0]  SEC_RESET    = 6'd0;
  localparam logic [5:0]  MIN_RESET    = 6'd23;
  localparam logic [4:0]  HOUR_RESET   = 5'd18;
  localparam logic [4:0]  DAY_RESET    = 5'd26;
  localparam logic [3:0]  MONTH_RESET  = 4'd6;
  localparam logic [15:0] YEAR_RESET   = 16'd2016;

  localparam int Q_DEPTH = 2;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_SET  = 1'b1
  } jcc_op_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_EMIT
  } jcc_bk_state_t;

  typedef struct packed {
    logic        command;
    logic [15:0] timer_sample;
    logic [15:0] set_year;
    logic [3:0]  set_month;
    logic [4:0]  set_day;
    logic [4:0]  set_hour;
    logic [5:0]  set_minute;
    logic [5:0]  set_second;
  } jcc_in_t;

  typedef struct packed {
    logic [5:0]  cur_second;
    logic [5:0]  cur_minute;
    logic [4:0]  cur_hour;
    logic [4:0]  cur_day;
    logic [3:0]  cur_month;
    logic [15:0] cur_year;
    logic [31:0] seconds_since_set;
  } jcc_out_t;

  typedef struct packed {
    jcc_op_t     op;
    logic [15:0] sample;
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } jcc_cmd_t;

  typedef struct packed {
    logic       full;
    logic       empty;
    logic [1:0] count;
  } jcc_q_stat_t;

  typedef struct packed {
    logic pop;
    logic busy;
  } jcc_bk_stat_t;

  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    unique case (m) inside
      4'd1:                      len = 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
      default:                   len = LONG_MONTH;
    endcase
    return len;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/jcc_front.sv
`default_nettype none
module jcc_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire jcc_pkg::jcc_in_t in_data,
  output logic                  push_valid,
  input  wire logic             push_ready,
  output jcc_pkg::jcc_cmd_t     push_data
);
  import jcc_pkg::*;

  logic     hold_valid_r;
  jcc_cmd_t hold_r;
  jcc_cmd_t decoded;

  always_comb begin
    decoded.op     = in_data.command ? OP_SET : OP_TICK;
    decoded.sample = in_data.timer_sample;
    decoded.year   = in_data.set_year;
    decoded.month  = in_data.set_month;
    decoded.day    = in_data.set_day;
    decoded.hour   = in_data.set_hour;
    decoded.minute = in_data.set_minute;
    decoded.second = in_data.set_second;
  end

  assign in_ready   = !hold_valid_r || push_ready;
  assign push_valid = hold_valid_r;
  assign push_data  = hold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (in_ready) begin
      hold_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_r <= decoded;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/jcc_queue.sv
`default_nettype none
module jcc_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push_valid,
  output logic                   push_ready,
  input  wire jcc_pkg::jcc_cmd_t push_data,
  output logic                   pop_valid,
  input  wire logic              pop,
  output jcc_pkg::jcc_cmd_t      pop_data,
  output jcc_pkg::jcc_q_stat_t   stat
);
  import jcc_pkg::*;

  jcc_cmd_t   mem_r [Q_DEPTH];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count_r != 2'(Q_DEPTH));
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    stat.full  = !push_ready;
    stat.empty = !pop_valid;
    stat.count = count_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 2'd1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/jcc_back.sv
`default_nettype none
module jcc_back #(
  parameter int TIMER_BITS = jcc_pkg::TIMER_BITS_DEF,
  parameter int YEAR_BITS  = jcc_pkg::YEAR_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [15:0]       tps,
  input  wire logic              cmd_valid,
  input  wire jcc_pkg::jcc_cmd_t cmd,
  output jcc_pkg::jcc_bk_stat_t  stat,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output jcc_pkg::jcc_out_t      out_data
);
  import jcc_pkg::*;

  localparam logic [31:0] LOW_MASK = 32'((64'd1 << TIMER_BITS) - 64'd1);
  localparam logic [32:0] WRAP_ADD = 33'(64'd1 << TIMER_BITS);
  localparam logic [YEAR_BITS-1:0] INV25 = YEAR_BITS'(23593);
  localparam logic [YEAR_BITS-1:0] DIV25_MAX = YEAR_BITS'(((1 << YEAR_BITS) - 1) / 25);

  jcc_bk_state_t state_r, state_nxt;

  logic [31:0]          jiffy_r, mark_r, elapsed_r;
  logic [5:0]           sec_r, min_r;
  logic [4:0]           hour_r, day_r;
  logic [3:0]           month_r;
  logic [YEAR_BITS-1:0] year_r;
  logic                 leap_r;
  logic                 out_valid_r;
  jcc_out_t             out_r;

  logic pop, load_set, load_tick, step, emit, reached;

  logic [31:0]          rate32, sample_m, low, diff, jiffy_nxt;
  logic [32:0]          cnt;
  logic [YEAR_BITS-1:0] year_prod;
  logic                 div25, leap_nxt;
  logic [5:0]           sec_inc, min_inc, day_inc6, limit6;
  logic [4:0]           hour_inc, month_mid;
  logic                 sec_wrap, min_wrap, hour_wrap, day_wrap, month_over;

  assign rate32   = (tps == 16'd0) ? 32'd1 : 32'(tps);
  assign sample_m = 32'(cmd.sample) & LOW_MASK;
  assign low      = jiffy_r & LOW_MASK;
  assign cnt      = {1'b0, jiffy_r} + ((sample_m < low) ? WRAP_ADD : 33'd0);
  assign jiffy_nxt = (cnt[31:0] & ~LOW_MASK) | sample_m;
  assign diff     = jiffy_r - mark_r;
  assign reached  = !diff[31];

  assign year_prod = YEAR_BITS'(year_r * INV25);
  assign div25     = (year_prod <= DIV25_MAX);
  assign leap_nxt  = (year_r[1:0] == 2'd0) && (!div25 || (year_r[3:0] == 4'd0));

  always_comb begin
    sec_inc    = sec_r + 6'd1;
    sec_wrap   = (sec_inc >= SEC_LIMIT) || (sec_inc == 6'd0);
    min_inc    = min_r + 6'd1;
    min_wrap   = (min_inc >= MIN_LIMIT) || (min_inc == 6'd0);
    hour_inc   = hour_r + 5'd1;
    hour_wrap  = (hour_inc >= HOUR_LIMIT) || (hour_inc == 5'd0);
    day_inc6   = {1'b0, day_r} + 6'd1;
    limit6     = {1'b0, month_len(month_r)} +
                 6'((month_r == MONTH_FEB) && leap_r);
    day_wrap   = (day_inc6 > limit6);
    month_mid  = {1'b0, month_r} + 5'(day_wrap);
    month_over = (month_mid > LAST_MONTH);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (cmd_valid) begin
          state_nxt = (cmd.op == OP_SET) ? BK_EMIT : BK_RUN;
        end
      end
      BK_RUN: begin
        if (!reached) begin
          state_nxt = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    pop       = (state_r == BK_IDLE) && cmd_valid;
    load_set  = pop && (cmd.op == OP_SET);
    load_tick = pop && (cmd.op == OP_TICK);
    step      = (state_r == BK_RUN) && reached;
    emit      = (state_r == BK_EMIT) && (!out_valid_r || out_ready);
  end

  always_comb begin
    stat.pop  = pop;
    stat.busy = (state_r != BK_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jiffy_r   <= 32'd0;
      mark_r    <= 32'(TPS_RESET);
      elapsed_r <= 32'd0;
      sec_r     <= SEC_RESET;
      min_r     <= MIN_RESET;
      hour_r    <= HOUR_RESET;
      day_r     <= DAY_RESET;
      month_r   <= MONTH_RESET;
      year_r    <= YEAR_RESET[YEAR_BITS-1:0];
    end else if (load_set) begin
      jiffy_r   <= 32'd0;
      mark_r    <= rate32;
      elapsed_r <= 32'd0;
      sec_r     <= cmd.second;
      min_r     <= cmd.minute;
      hour_r    <= cmd.hour;
      day_r     <= cmd.day;
      month_r   <= cmd.month;
      year_r    <= cmd.year[YEAR_BITS-1:0];
    end else if (load_tick) begin
      jiffy_r <= jiffy_nxt;
    end else if (step) begin
      mark_r    <= mark_r + rate32;
      elapsed_r <= elapsed_r + 32'd1;
      sec_r     <= sec_wrap ? 6'd0 : sec_inc;
      if (sec_wrap) begin
        min_r <= min_wrap ? 6'd0 : min_inc;
      end
      if (sec_wrap && min_wrap) begin
        hour_r <= hour_wrap ? 5'd0 : hour_inc;
      end
      if (sec_wrap && min_wrap && hour_wrap) begin
        day_r   <= day_wrap ? 5'd1 : day_inc6[4:0];
        month_r <= month_over ? 4'd0 : month_mid[3:0];
        if (month_over) begin
          year_r <= year_r + YEAR_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    leap_r <= leap_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_r.cur_second        <= sec_r;
      out_r.cur_minute        <= min_r;
      out_r.cur_hour          <= hour_r;
      out_r.cur_day           <= day_r;
      out_r.cur_month         <= month_r;
      out_r.cur_year          <= 16'(year_r);
      out_r.seconds_since_set <= elapsed_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

FILE: rtl/core/jiffy_calendar_clock.sv
// Calendar clock driven by samples of a free-running jiffy timer.
// Input words on in_data carry either a tick with a timer sample or a set
// command that loads the calendar and clears the jiffy and seconds counts.
// Every input word yields exactly one output word on out_data with the
// calendar after that word and the seconds counted since the last set.
// The cfg port writes ticks_per_second at any time the block is idle.
// A front stage registers and decodes words into a two-entry queue, and
// the back unit executes them one at a time.
// A set word passes the front register and the queue, and the back unit
// goes straight to its emit state. For a tick word it first advances the
// calendar one second per cycle for each whole second the word brings.
// The back unit takes no new word until it has emitted the last one.
// After reset the calendar reads 2016, month 6 (0-based), day 26, 18:23:00,
// and ticks_per_second is 60.
// When the receiver stalls, the output word holds and the queue keeps
// taking input words until it and the front stage are full.
`default_nettype none
module jiffy_calendar_clock #(
  parameter int TIMER_BITS = jcc_pkg::TIMER_BITS_DEF,
  parameter int YEAR_BITS  = jcc_pkg::YEAR_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire jcc_pkg::jcc_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output jcc_pkg::jcc_out_t      out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [15:0]       cfg_data
);
  import jcc_pkg::*;

  logic         tps_r;
  logic [15:0]  tps_val_r;
  logic         push_valid, push_ready, q_valid;
  jcc_cmd_t     push_data, q_data;
  jcc_q_stat_t  q_stat;
  jcc_bk_stat_t bk_stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r     <= 1'b0;
      tps_val_r <= TPS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      tps_r     <= 1'b1;
      tps_val_r <= cfg_data;
    end
  end

  jcc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  jcc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (q_valid),
    .pop        (bk_stat.pop),
    .pop_data   (q_data),
    .stat       (q_stat)
  );

  jcc_back #(
    .TIMER_BITS (TIMER_BITS),
    .YEAR_BITS  (YEAR_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tps       (tps_val_r),
    .cmd_valid (q_valid),
    .cmd       (q_data),
    .stat      (bk_stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= 2'(Q_DEPTH))
    else $error("queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.pop |-> !q_stat.empty)
    else $error("back unit popped an empty queue");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !tps_r)
    else $error("output or config state not cleared by reset");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.pop |=> bk_stat.busy)
    else $error("back unit not busy after taking a word");

endmodule
`default_nettype wire

FILE: tb/jiffy_calendar_clock_test.sv
`timescale 1ns / 100ps
module jiffy_calendar_clock_test;
  import jcc_pkg::*;

  localparam int PHASES = 7;
  localparam int PHASE_WORDS = 75;
  localparam int HOLD_AT = 150;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 2_000_000;

  class calendar_board;
    logic [15:0] jiffies_per_second;
    logic [31:0] jiffies;
    logic [31:0] mark;
    logic [31:0] elapsed;
    logic [5:0] sec;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [4:0] day;
    logic [3:0] month;
    logic [15:0] year;
    jcc_out_t expected_times[$];
    int errors;

    function new();
      jiffies_per_second = TPS_RESET;
      jiffies = '0;
      mark = {16'd0, TPS_RESET};
      elapsed = '0;
      sec = SEC_RESET;
      minute = MIN_RESET;
      hour = HOUR_RESET;
      day = DAY_RESET;
      month = MONTH_RESET;
      year = YEAR_RESET;
      errors = 0;
    endfunction

    function int month_span(logic [3:0] m);
      case (m)
        4'd1: return 28;
        4'd3, 4'd5, 4'd8, 4'd10: return 30;
        default: return 31;
      endcase
    endfunction

    function bit leap_year(int y);
      if (y % 4 != 0) return 1'b0;
      if (y % 100 != 0) return 1'b1;
      return (y % 400 == 0);
    endfunction

    function void step_second();
      logic [5:0] day_next;
      logic [4:0] month_next;
      int limit;
      sec = sec + 6'd1;
      if (sec < SEC_LIMIT && sec != 6'd0) return;
      sec = '0;
      minute = minute + 6'd1;
      if (minute < MIN_LIMIT && minute != 6'd0) return;
      minute = '0;
      hour = hour + 5'd1;
      if (hour < HOUR_LIMIT && hour != 5'd0) return;
      hour = '0;
      day_next = {1'b0, day} + 6'd1;
      month_next = {1'b0, month};
      limit = ({1'b0, month} <= LAST_MONTH) ? month_span(month) : 31;
      if (month == MONTH_FEB && leap_year(int'(year))) limit++;
      if (int'(day_next) > limit) begin
        day_next = 6'd1;
        month_next = month_next + 5'd1;
      end
      day = day_next[4:0];
      if (month_next > LAST_MONTH) begin
        month_next = '0;
        year = year + 16'd1;
      end
      month = month_next[3:0];
    endfunction

    function void note_word(jcc_in_t w);
      logic [31:0] stride;
      jcc_out_t e;
      stride = (jiffies_per_second == 16'd0) ? 32'd1 : {16'd0, jiffies_per_second};
      if (w.command == OP_SET) begin
        jiffies = '0;
        elapsed = '0;
        mark = stride;
        year = w.set_year;
        month = w.set_month;
        day = w.set_day;
        hour = w.set_hour;
        minute = w.set_minute;
        sec = w.set_second;
      end else begin
        if (w.timer_sample < jiffies[15:0]) jiffies[31:16] = jiffies[31:16] + 16'd1;
        jiffies[15:0] = w.timer_sample;
        while (jiffies - mark < 32'h8000_0000) begin
          mark = mark + stride;
          elapsed = elapsed + 32'd1;
          step_second();
        end
      end
      e.cur_second = sec;
      e.cur_minute = minute;
      e.cur_hour = hour;
      e.cur_day = day;
      e.cur_month = month;
      e.cur_year = year;
      e.seconds_since_set = elapsed;
      expected_times.push_back(e);
    endfunction

    function void compare_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_word(jcc_out_t got);
      jcc_out_t want;
      if (expected_times.size() == 0) begin
        $error("result word arrived with no expectation pending");
        errors++;
        return;
      end
      want = expected_times.pop_front();
      compare_field("cur_second", want.cur_second, got.cur_second);
      compare_field("cur_minute", want.cur_minute, got.cur_minute);
      compare_field("cur_hour", want.cur_hour, got.cur_hour);
      compare_field("cur_day", want.cur_day, got.cur_day);
      compare_field("cur_month", want.cur_month, got.cur_month);
      compare_field("cur_year", want.cur_year, got.cur_year);
      compare_field("seconds_since_set", want.seconds_since_set, got.seconds_since_set);
    endfunction

    function int pending();
      return expected_times.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  jcc_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  jcc_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [15:0] cfg_data = '0;

  calendar_board board;
  int idle_mode = 0;
  bit hold_request = 1'b0;
  logic [15:0] timer_now = '0;

  always #10 clk = ~clk;

  jiffy_calendar_clock dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  function automatic int source_gap_pct(int mode);
    case (mode)
      0: return 23;
      1: return 51;
      default: return 0;
    endcase
  endfunction

  function automatic int sink_stall_pct(int mode);
    case (mode)
      0: return 51;
      1: return 23;
      default: return 0;
    endcase
  endfunction

  function automatic jcc_in_t noise_word();
    logic [63:0] noise;
    jcc_in_t w;
    noise = {$urandom, $urandom};
    w = noise[$bits(jcc_in_t)-1:0];
    return w;
  endfunction

  function automatic jcc_in_t make_tick(logic [15:0] sample);
    jcc_in_t w;
    w = noise_word();
    w.command = OP_TICK;
    w.timer_sample = sample;
    return w;
  endfunction

  function automatic jcc_in_t make_set(logic [15:0] y, logic [3:0] mo, logic [4:0] d,
                                       logic [4:0] h, logic [5:0] mi, logic [5:0] s);
    jcc_in_t w;
    w = noise_word();
    w.command = OP_SET;
    w.set_year = y;
    w.set_month = mo;
    w.set_day = d;
    w.set_hour = h;
    w.set_minute = mi;
    w.set_second = s;
    return w;
  endfunction

  // Most set words land just before a carry so that ticks walk through the calendar.
  function automatic jcc_in_t random_word(logic [15:0] tps, logic [15:0] now);
    jcc_in_t w;
    int unsigned stride;
    int unsigned span;
    w = noise_word();
    stride = (tps == 16'd0) ? 1 : tps;
    span = (stride * 100 > 65535) ? 65535 : stride * 100;
    if ($urandom_range(5) == 0) begin
      w.command = OP_SET;
      if ($urandom_range(3) != 0) begin
        case ($urandom_range(2))
          0: w.set_year = 16'($urandom_range(655) * 100);
          1: w.set_year = 16'($urandom_range(16383) * 4);
          default: ;
        endcase
        w.set_month = 4'($urandom_range(11));
        w.set_day = 5'($urandom_range(27, 31));
        w.set_hour = 5'($urandom_range(22, 23));
        w.set_minute = 6'($urandom_range(57, 59));
        w.set_second = 6'($urandom_range(50, 59));
      end
    end else begin
      w.command = OP_TICK;
      if (!(stride >= 60 && $urandom_range(15) == 0)) begin
        if ($urandom_range(3) == 0 && stride < span) span = stride;
        w.timer_sample = now + 16'($urandom_range(span));
      end
    end
    return w;
  endfunction

  function automatic logic [15:0] phase_rate(int p);
    case (p)
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'hFFFF;
      3: return 16'd60;
      4: return 16'($urandom_range(2, 65534));
      5: return 16'd1000;
      default: return 16'd60;
    endcase
  endfunction

  task automatic send_word(input jcc_in_t w);
    int pct;
    pct = source_gap_pct(idle_mode);
    if ($urandom_range(99) < pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < pct);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    board.note_word(w);
    timer_now = (w.command == OP_SET) ? 16'd0 : w.timer_sample;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_rate(input logic [15:0] v);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.jiffies_per_second = v;
  endtask

  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) board.check_word(out_data);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= sink_stall_pct(idle_mode));
      end
    end
  end

  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("jiffy_calendar_clock_test: FAIL");
    $finish;
  end

  initial begin : stimulus
    logic [15:0] rate_now;
    int k;
    board = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(make_tick(16'd0));
    send_word(make_tick(16'd59));
    send_word(make_tick(16'd60));
    send_word(make_tick(16'd65535));
    send_word(make_tick(16'd10));
    send_word(make_set(16'd2023, 4'd1, 5'd28, 5'd23, 6'd59, 6'd59));
    send_word(make_tick(16'd60));
    send_word(make_set(16'd2024, 4'd1, 5'd28, 5'd23, 6'd59, 6'd59));
    send_word(make_tick(16'd60));
    send_word(make_set(16'd1900, 4'd1, 5'd28, 5'd23, 6'd59, 6'd59));
    send_word(make_tick(16'd60));
    send_word(make_set(16'd2000, 4'd1, 5'd28, 5'd23, 6'd59, 6'd59));
    send_word(make_tick(16'd60));
    send_word(make_set(16'hFFFF, 4'd11, 5'd31, 5'd23, 6'd59, 6'd59));
    send_word(make_tick(16'd60));
    send_word(make_set(16'd0, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63));
    send_word(make_tick(16'd60));
    send_word(make_set(16'h8000, 4'd12, 5'd0, 5'd23, 6'd59, 6'd59));
    send_word(make_tick(16'd60));
    send_word(make_set(16'd2021, 4'd3, 5'd30, 5'd24, 6'd60, 6'd60));
    send_word(make_tick(16'd60));
    send_word(make_set(16'd2020, 4'd4, 5'd15, 5'd10, 6'd20, 6'd30));
    send_word(make_tick(16'd0));

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      rate_now = phase_rate(p);
      write_rate(rate_now);
      // At the slowest rates one full timer lap forces the longest run of seconds.
      if (rate_now <= 16'd1) send_word(make_tick(timer_now - 16'd1));
      for (int i = 0; i < PHASE_WORDS; i++) begin
        k = p * PHASE_WORDS + i;
        idle_mode = k * 3 / (PHASES * PHASE_WORDS);
        if (k == HOLD_AT) hold_request = 1'b1;
        send_word(random_word(rate_now, timer_now));
      end
    end

    wait_drained();
    repeat (12) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("jiffy_calendar_clock_test: PASS");
    end else begin
      $display("jiffy_calendar_clock_test: FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/jcc_pkg.sv
rtl/core/jcc_front.sv
rtl/core/jcc_queue.sv
rtl/core/jcc_back.sv
rtl/core/jiffy_calendar_clock.sv
tb/jiffy_calendar_clock_test.sv
